// ===== hdl/bustk_pkg.sv =====
package bustk_pkg;

   localparam int VALUE_W = 32;
   localparam int COUNT_W = 8;
   localparam int LIMIT_W = 8;

   localparam logic [LIMIT_W-1:0] LIMIT_RESET = 8'd100;
   localparam logic [LIMIT_W-1:0] LIMIT_MIN   = 8'd2;

   typedef enum logic [2:0] {
      FN_PUSH,
      FN_POP_TOP,
      FN_DROP_SECOND_TOP,
      FN_POP_BOTTOM,
      FN_DROP_SECOND_BOTTOM
   } func_type;

   typedef enum logic [1:0] {
      ST_OK,
      ST_EMPTY,
      ST_FEW,
      ST_DROPPED
   } status_type;

   typedef logic signed [VALUE_W-1:0] value_type;
   typedef logic [COUNT_W-1:0]        count_type;
   typedef logic [LIMIT_W-1:0]        limit_type;

endpackage

// ===== hdl/bustk_if.sv =====
interface bustk_req_if;
   logic                 valid;
   logic                 ready;
   bustk_pkg::func_type  func;
   bustk_pkg::value_type value;

   modport source (output valid, output func, output value, input ready);
   modport sink   (input valid, input func, input value, output ready);
endinterface

interface bustk_rsp_if;
   logic                   valid;
   logic                   ready;
   bustk_pkg::status_type  status;
   bustk_pkg::count_type   count;
   bustk_pkg::value_type   top_value;

   modport source (output valid, output status, output count, output top_value, input ready);
   modport sink   (input valid, input status, input count, input top_value, output ready);
endinterface

interface bustk_csr_if;
   logic                 valid;
   logic                 ready;
   bustk_pkg::limit_type max_entries;

   modport source (output valid, output max_entries, input ready);
   modport sink   (input valid, input max_entries, output ready);
endinterface

// ===== hdl/bounded_undo_stack.sv =====
// channel   dir   payload                     handshake
// req_if    in    func, value                 valid/ready
// rsp_if    out   status, count, top_value    valid/ready
// csr_if    in    max_entries                 valid/ready, always ready
//
// one word per cycle while req ready is high; the result appears in the output register in the cycle after accept
// the ring store has one write and two registered read ports; top entry kept in a register
// reset (synchronous) clears count, oldest slot and output valid, and loads the limit of 100
// req ready drops only while a result is held and rsp ready is low
module bounded_undo_stack #(
   parameter int DEPTH = 128
) (
   input  logic         clock,
   input  logic         reset,
   bustk_req_if.sink    req_if,
   bustk_rsp_if.source  rsp_if,
   bustk_csr_if.sink    csr_if
);

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int SW = ((AW > bustk_pkg::COUNT_W) ? AW : bustk_pkg::COUNT_W) + 1;

   function automatic logic [AW-1:0] slot_of(input logic [AW-1:0] base,
                                             input bustk_pkg::count_type offs);
      logic [SW-1:0] sum;
      sum = SW'(base) + SW'(offs);
      if (sum >= SW'(DEPTH)) begin
         sum = sum - SW'(DEPTH);
      end
      return sum[AW-1:0];
   endfunction

   function automatic logic [AW-1:0] next_slot(input logic [AW-1:0] base);
      logic [AW-1:0] res;
      if (SW'(base) == SW'(DEPTH - 1)) begin
         res = '0;
      end else begin
         res = base + AW'(1);
      end
      return res;
   endfunction

   bustk_pkg::value_type ring_mem [DEPTH];

   bustk_pkg::count_type  count_ff, count_in;
   logic [AW-1:0]         oldest_ff, oldest_in;
   bustk_pkg::value_type  top_ff, top_in;
   bustk_pkg::value_type  sec_ff;
   bustk_pkg::value_type  bot_ff;
   bustk_pkg::limit_type  limit_ff;

   logic                   rsp_valid_ff;
   bustk_pkg::status_type  rsp_status_ff;
   bustk_pkg::count_type   rsp_count_ff;
   bustk_pkg::value_type   rsp_top_ff;

   logic [SW-1:0]          limit;
   logic                   take;
   bustk_pkg::status_type  status;
   logic                   wr_en;
   logic [AW-1:0]          wr_addr;
   bustk_pkg::value_type   wr_data;
   logic [AW-1:0]          sec_addr;
   logic [AW-1:0]          bot_addr;
   logic                   sec_hit;
   logic                   bot_hit;

   assign req_if.ready = !rsp_valid_ff || rsp_if.ready;
   assign csr_if.ready = 1'b1;
   assign take         = req_if.valid && req_if.ready;

   assign rsp_if.valid     = rsp_valid_ff;
   assign rsp_if.status    = rsp_status_ff;
   assign rsp_if.count     = rsp_count_ff;
   assign rsp_if.top_value = rsp_top_ff;

   // clamp the entry limit into 2..DEPTH
   always_comb begin
      if (limit_ff < bustk_pkg::LIMIT_MIN) begin
         limit = SW'(bustk_pkg::LIMIT_MIN);
      end else if (SW'(limit_ff) > SW'(DEPTH)) begin
         limit = SW'(DEPTH);
      end else begin
         limit = SW'(limit_ff);
      end
   end

   always_comb begin
      count_in  = count_ff;
      oldest_in = oldest_ff;
      top_in    = top_ff;
      status    = bustk_pkg::ST_OK;
      wr_en     = 1'b0;
      wr_addr   = slot_of(oldest_ff, count_ff);
      wr_data   = req_if.value;
      if (take) begin
         case (req_if.func)
            bustk_pkg::FN_PUSH: begin
               wr_en  = 1'b1;
               top_in = req_if.value;
               if (SW'(count_ff) >= limit) begin
                  oldest_in = next_slot(oldest_ff);
                  status    = bustk_pkg::ST_DROPPED;
               end else begin
                  count_in = count_ff + 8'd1;
               end
            end
            bustk_pkg::FN_POP_TOP: begin
               if (count_ff == '0) begin
                  status = bustk_pkg::ST_EMPTY;
               end else begin
                  count_in = count_ff - 8'd1;
                  top_in   = sec_ff;
               end
            end
            bustk_pkg::FN_DROP_SECOND_TOP: begin
               if (count_ff == '0) begin
                  status = bustk_pkg::ST_EMPTY;
               end else if (count_ff < 8'd2) begin
                  status = bustk_pkg::ST_FEW;
               end else begin
                  wr_en    = 1'b1;
                  wr_addr  = slot_of(oldest_ff, count_ff - 8'd2);
                  wr_data  = top_ff;
                  count_in = count_ff - 8'd1;
               end
            end
            bustk_pkg::FN_POP_BOTTOM: begin
               if (count_ff == '0) begin
                  status = bustk_pkg::ST_EMPTY;
               end else begin
                  oldest_in = next_slot(oldest_ff);
                  count_in  = count_ff - 8'd1;
               end
            end
            bustk_pkg::FN_DROP_SECOND_BOTTOM: begin
               if (count_ff == '0) begin
                  status = bustk_pkg::ST_EMPTY;
               end else if (count_ff < 8'd2) begin
                  status = bustk_pkg::ST_FEW;
               end else begin
                  wr_en     = 1'b1;
                  wr_addr   = slot_of(oldest_ff, 8'd1);
                  wr_data   = bot_ff;
                  oldest_in = next_slot(oldest_ff);
                  count_in  = count_ff - 8'd1;
                  if (count_ff == 8'd2) begin
                     top_in = bot_ff;
                  end
               end
            end
            default: begin
               status = bustk_pkg::ST_OK;
            end
         endcase
      end
   end

   // prefetch second-from-top and bottom of the next state
   assign sec_addr = slot_of(oldest_in, (count_in >= 8'd2) ? count_in - 8'd2 : 8'd0);
   assign bot_addr = oldest_in;
   assign sec_hit  = wr_en && (wr_addr == sec_addr);
   assign bot_hit  = wr_en && (wr_addr == bot_addr);

   always_ff @(posedge clock) begin
      if (wr_en) begin
         ring_mem[wr_addr] <= wr_data;
      end
      sec_ff <= sec_hit ? wr_data : ring_mem[sec_addr];
      bot_ff <= bot_hit ? wr_data : ring_mem[bot_addr];
   end

   always_ff @(posedge clock) begin
      top_ff <= top_in;
      if (take) begin
         rsp_status_ff <= status;
         rsp_count_ff  <= count_in;
         rsp_top_ff    <= (count_in == '0) ? '0 : top_in;
      end
      if (reset) begin
         count_ff     <= '0;
         oldest_ff    <= '0;
         limit_ff     <= bustk_pkg::LIMIT_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff  <= count_in;
         oldest_ff <= oldest_in;
         if (csr_if.valid && csr_if.ready) begin
            limit_ff <= csr_if.max_entries;
         end
         if (take) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_if.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

endmodule
